[sv/gma_pkg.sv]
// Shared constants, types and helper functions of the Gram matrix accumulator.
package gma_pkg;

	// Sizes of the point store and the lower-triangle sum store
	localparam int MAX_DIMS   = 16;
	localparam int DIM_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CNT_W      = $clog2(MAX_DIMS + 1);
	localparam int TRI_SIZE   = MAX_DIMS * (MAX_DIMS + 1) / 2;
	localparam int TRI_W      = (TRI_SIZE > 1) ? $clog2(TRI_SIZE) : 1;

	// Field widths
	localparam int SAMPLE_W   = 16;
	localparam int PROD_W     = 2 * SAMPLE_W;
	localparam int SUM_W      = 64;
	localparam int DIMS_W     = 5;
	localparam int IDX_W      = 4;

	// Queue sizes
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = 2;
	localparam int OUTQ_DEPTH = 2;
	localparam int OUTQ_PTR_W = 1;

	localparam logic [DIMS_W-1:0] DIMS_RESET = 5'd16;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// Operation codes
	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_READ,
		ST_RESULT
	} back_state_t;

	// Classified command from front to back
	typedef struct packed {
		op_t                        op;
		logic signed [SAMPLE_W-1:0] sample;
		logic [DIM_W-1:0]           pos;
		logic [TRI_W-1:0]           base;
		logic                       last;
		logic                       ierr;
	} cmd_t;

	// One result transaction
	typedef struct packed {
		logic signed [SUM_W-1:0] read_value;
		logic                    read_valid;
		logic                    index_error;
		logic                    chunk_done;
		logic                    saturated;
	} res_t;

	// Clamp the dimension register into 1..MAX_DIMS
	function automatic logic [CNT_W-1:0] eff_dims(input logic [DIMS_W-1:0] d);
		logic [CNT_W-1:0] r;
		if (d == '0) begin
			r = CNT_W'(1);
		end else if (int'(d) > MAX_DIMS) begin
			r = CNT_W'(MAX_DIMS);
		end else begin
			r = CNT_W'(d);
		end
		return r;
	endfunction

	// Offset of row r in the packed lower triangle
	function automatic logic [TRI_W-1:0] tri_base(input logic [DIM_W-1:0] r);
		int prod;
		prod = int'(r) * (int'(r) + 1);
		return TRI_W'(prod >> 1);
	endfunction

endpackage

[sv/gma_front.sv]
// Front end: configuration register, dimension tracking and command classification.
module gma_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic                                 full,
	input  logic [1:0]                           opcode,
	input  logic signed [gma_pkg::SAMPLE_W-1:0]  sample_value,
	input  logic [gma_pkg::IDX_W-1:0]            row_index,
	input  logic [gma_pkg::IDX_W-1:0]            col_index,
	input  logic                                 last_in_chunk,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gma_pkg::DIMS_W-1:0]           cfg_dims_in_use,
	output logic                                 cmd_push,
	output gma_pkg::cmd_t                        cmd
);
	import gma_pkg::*;

	logic [DIMS_W-1:0] dims_q;
	logic [DIM_W-1:0]  pos_q;
	logic [CNT_W-1:0]  eff;
	logic [DIM_W-1:0]  pos_cur;
	logic [DIM_W-1:0]  pos_next;
	logic [IDX_W-1:0]  hi_idx;
	logic [IDX_W-1:0]  lo_idx;
	logic              rd_err;
	logic [TRI_W-1:0]  rd_addr;
	op_t               op;

	assign cfg_ready = 1'b1;
	assign cmd_push  = push && !full;
	assign op        = op_t'(opcode);
	assign eff       = eff_dims(dims_q);

	// Resolve the dimension of this sample, restart on a stale position
	always_comb begin
		pos_cur  = (int'(pos_q) >= int'(eff)) ? '0 : pos_q;
		pos_next = ((int'(pos_cur) + 1) >= int'(eff)) ? '0 : pos_cur + DIM_W'(1);
	end

	// Order the read indices so the row is the larger one
	always_comb begin
		hi_idx  = (col_index > row_index) ? col_index : row_index;
		lo_idx  = (col_index > row_index) ? row_index : col_index;
		rd_err  = int'(hi_idx) >= int'(eff);
		rd_addr = tri_base(DIM_W'(hi_idx)) + TRI_W'(lo_idx);
	end

	// Build the command for the back end
	always_comb begin
		cmd        = '0;
		cmd.op     = op;
		cmd.sample = sample_value;
		unique case (op)
			OP_SAMPLE: begin
				cmd.pos  = pos_cur;
				cmd.base = tri_base(pos_cur);
				cmd.last = last_in_chunk;
			end
			OP_READ: begin
				cmd.base = rd_addr;
				cmd.ierr = rd_err;
			end
			default: begin
			end
		endcase
	end

	// Hold the dimension count; advance the position on each sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= DIMS_RESET;
			pos_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			dims_q <= cfg_dims_in_use;
			pos_q  <= '0;
		end else if (cmd_push && op == OP_SAMPLE) begin
			pos_q <= pos_next;
		end
	end

endmodule

[sv/gma_cmdq.sv]
// Command queue between the front end and the back end.
module gma_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  gma_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output gma_pkg::cmd_t rd_data,
	output logic          empty
);
	import gma_pkg::*;

	cmd_t                  slot_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wptr_q;
	logic [CMDQ_PTR_W-1:0] rptr_q;
	logic [CMDQ_PTR_W:0]   count_q;

	assign full    = count_q == (CMDQ_PTR_W+1)'(CMDQ_DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = slot_q[rptr_q];

	// Store the incoming command
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + CMDQ_PTR_W'(1);
			end
			if (rd_en) begin
				rptr_q <= rptr_q + CMDQ_PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + (CMDQ_PTR_W+1)'(1);
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - (CMDQ_PTR_W+1)'(1);
			end
		end
	end

endmodule

[sv/gma_back.sv]
// Back end: point store, shared multiply-accumulate unit and the sum memory.
module gma_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_vld,
	input  gma_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output gma_pkg::res_t res
);
	import gma_pkg::*;

	back_state_t                state_q;
	back_state_t                state_d;
	cmd_t                       cur_q;
	logic [DIM_W-1:0]           k_q;
	logic                       sat_q;
	logic signed [SAMPLE_W-1:0] pv_q [MAX_DIMS];

	logic [SUM_W-1:0]           mem_q [TRI_SIZE];
	logic [TRI_SIZE-1:0]        vld_q;

	logic [TRI_W-1:0]           rd_addr;
	logic [SUM_W-1:0]           rdata_s1;
	logic                       rvld_s1;
	logic signed [PROD_W-1:0]   prod_s1;
	logic [TRI_W-1:0]           waddr_s1;
	logic                       wen_s1;

	logic                       mac_issue;
	logic                       clear_all;
	logic [SUM_W-1:0]           acc_a;
	logic [SUM_W-1:0]           acc_b;
	logic [SUM_W-1:0]           acc_sum;
	logic [SUM_W-1:0]           acc_new;
	logic                       ovf;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_vld && !res_full) begin
					case (cmd.op)
						OP_SAMPLE: state_d = ST_MAC;
						OP_READ:   state_d = cmd.ierr ? ST_RESULT : ST_READ;
						default:   state_d = ST_RESULT;
					endcase
				end
			end
			ST_MAC: begin
				if (k_q == cur_q.pos) begin
					state_d = ST_RESULT;
				end
			end
			ST_READ:   state_d = ST_RESULT;
			ST_RESULT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		cmd_pop   = 1'b0;
		mac_issue = 1'b0;
		res_push  = 1'b0;
		unique case (state_q)
			ST_IDLE:   cmd_pop   = cmd_vld && !res_full;
			ST_MAC:    mac_issue = 1'b1;
			ST_READ:   ;
			ST_RESULT: res_push  = 1'b1;
			default:   ;
		endcase
	end

	assign clear_all = res_push && cur_q.op == OP_CLEAR;
	assign rd_addr   = mac_issue ? cur_q.base + TRI_W'(k_q) : cur_q.base;

	// Saturating accumulate of the registered product into the registered sum
	always_comb begin
		acc_a   = rvld_s1 ? rdata_s1 : '0;
		acc_b   = {{(SUM_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		acc_sum = acc_a + acc_b;
		ovf     = (acc_a[SUM_W-1] == acc_b[SUM_W-1]) &&
			(acc_sum[SUM_W-1] != acc_a[SUM_W-1]);
		if (ovf) begin
			acc_new = acc_a[SUM_W-1] ? SUM_MIN : SUM_MAX;
		end else begin
			acc_new = acc_sum;
		end
	end

	// Assemble the result
	always_comb begin
		res = '0;
		case (cur_q.op)
			OP_SAMPLE: begin
				res.chunk_done = cur_q.last;
				res.saturated  = sat_q || (wen_s1 && ovf);
			end
			OP_READ: begin
				res.index_error = cur_q.ierr;
				res.read_valid  = !cur_q.ierr;
				res.read_value  = (!cur_q.ierr && rvld_s1) ? rdata_s1 : '0;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wen_s1  <= 1'b0;
			k_q     <= '0;
			sat_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			wen_s1  <= mac_issue;
			if (cmd_pop) begin
				k_q   <= '0;
				sat_q <= 1'b0;
			end else begin
				if (mac_issue) begin
					k_q <= k_q + DIM_W'(1);
				end
				if (wen_s1 && ovf) begin
					sat_q <= 1'b1;
				end
			end
		end
	end

	// Latch the command and store the new coordinate
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
			if (cmd.op == OP_SAMPLE) begin
				pv_q[cmd.pos] <= cmd.sample;
			end
		end
	end

	// Multiply stage and registered memory read
	always_ff @(posedge clk) begin
		prod_s1  <= PROD_W'(cur_q.sample) * PROD_W'(pv_q[k_q]);
		waddr_s1 <= rd_addr;
		rdata_s1 <= mem_q[rd_addr];
	end

	// Write back the accumulated sum
	always_ff @(posedge clk) begin
		if (wen_s1) begin
			mem_q[waddr_s1] <= acc_new;
		end
	end

	// Track written entries; an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= vld_q[rd_addr];
			if (clear_all) begin
				vld_q <= '0;
			end else if (wen_s1) begin
				vld_q[waddr_s1] <= 1'b1;
			end
		end
	end

endmodule

[sv/gma_outq.sv]
// Result queue in front of the output ports.
module gma_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  gma_pkg::res_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output gma_pkg::res_t rd_data,
	output logic          empty
);
	import gma_pkg::*;

	res_t                  slot_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wptr_q;
	logic [OUTQ_PTR_W-1:0] rptr_q;
	logic [OUTQ_PTR_W:0]   count_q;

	assign full    = count_q == (OUTQ_PTR_W+1)'(OUTQ_DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = slot_q[rptr_q];

	// Store the finished result
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + OUTQ_PTR_W'(1);
			end
			if (rd_en) begin
				rptr_q <= rptr_q + OUTQ_PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + (OUTQ_PTR_W+1)'(1);
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - (OUTQ_PTR_W+1)'(1);
			end
		end
	end

endmodule

[sv/gram_matrix_accumulator.sv]
// A sample runs one multiply-accumulate per dimension up to its own, a read one
// registered memory read; a clear, a failed read or an unused opcode goes to its result.
// Throughput: the back end's single multiply-accumulate unit takes one product per
// cycle and works on one command at a time.
// Reset: sums read as zero at once through per-entry valid bits (no clearing pass),
// dimension count 16, position 0, queues empty.
module gram_matrix_accumulator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [1:0]                          opcode,
	input  logic signed [gma_pkg::SAMPLE_W-1:0] sample_value,
	input  logic [gma_pkg::IDX_W-1:0]           row_index,
	input  logic [gma_pkg::IDX_W-1:0]           col_index,
	input  logic                                last_in_chunk,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gma_pkg::DIMS_W-1:0]          cfg_dims_in_use,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [gma_pkg::SUM_W-1:0]    read_value,
	output logic                                read_valid,
	output logic                                index_error,
	output logic                                chunk_done,
	output logic                                saturated
);
	import gma_pkg::*;

	cmd_t front_cmd;
	cmd_t head_cmd;
	res_t back_res;
	res_t out_res;
	logic cmd_push;
	logic cmd_pop;
	logic cmdq_empty;
	logic res_push;
	logic outq_full;

	// Classify incoming transactions
	gma_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.opcode          (opcode),
		.sample_value    (sample_value),
		.row_index       (row_index),
		.col_index       (col_index),
		.last_in_chunk   (last_in_chunk),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_dims_in_use (cfg_dims_in_use),
		.cmd_push        (cmd_push),
		.cmd             (front_cmd)
	);

	// Decouple front and back
	gma_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (front_cmd),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (head_cmd),
		.empty   (cmdq_empty)
	);

	// Execute commands
	gma_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_vld  (!cmdq_empty),
		.cmd      (head_cmd),
		.cmd_pop  (cmd_pop),
		.res_full (outq_full),
		.res_push (res_push),
		.res      (back_res)
	);

	// Hold results until popped
	gma_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (back_res),
		.full    (outq_full),
		.rd_en   (pop && !empty),
		.rd_data (out_res),
		.empty   (empty)
	);

	assign read_value  = out_res.read_value;
	assign read_valid  = out_res.read_valid;
	assign index_error = out_res.index_error;
	assign chunk_done  = out_res.chunk_done;
	assign saturated   = out_res.saturated;

endmodule

[sv/gma_checker.sv]
// Port-level checker for the Gram matrix accumulator and its bind.
module gma_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                empty,
	input logic                                pop,
	input logic signed [gma_pkg::SUM_W-1:0]    read_value,
	input logic                                read_valid,
	input logic                                index_error,
	input logic                                chunk_done,
	input logic                                saturated
);
	import gma_pkg::*;

	// A read either succeeds or flags its index, never both
	a_read_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(read_valid && index_error))
		else $error("read_valid and index_error both set");

	// No read data unless a read succeeded
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !read_valid) |-> (read_value == '0))
		else $error("read_value nonzero without read_valid");

	// Sample flags only come with sample transactions
	a_sample_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (chunk_done || saturated)) |-> (!read_valid && !index_error))
		else $error("sample flags mixed with read flags");

	// Hold a waiting result until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(read_value)))
		else $error("waiting result dropped or changed");

endmodule

bind gram_matrix_accumulator gma_checker u_gma_checker (.*);
